FILE: rtl/obw_pkg.sv
// ----------------------------------------------------------------------------
// obw_pkg - shared types and constants for origin_barycentric_weights
// Widths of the fixed point datapath, pipeline depths and result codes.
// ----------------------------------------------------------------------------
package obw_pkg;

   localparam int COORD_W    = 32;                    // Q16.16 vertex coordinate
   localparam int WFRAC      = 16;                    // weight fraction bits
   localparam int DIFF_W     = COORD_W + 1;           // edge vector component
   localparam int MUL_W      = 2 * DIFF_W + 2;        // widest multiplier operand
   localparam int LIMB_W     = (MUL_W + 2) / 3;       // partial product limb
   localparam int PROD_W     = 2 * MUL_W;             // multiplier product
   localparam int WIDE_W     = 2 * MUL_W + 2;         // D, S, T and clamped sums
   localparam int NUM_W      = WIDE_W + WFRAC + 2;    // divider dividend
   localparam int WGT_W      = WFRAC + 1;             // Q1.WFRAC weight

   localparam int MUL_LAT    = 4;
   localparam int DIV_LAT    = WGT_W + 1;
   localparam int PIPE_LAT   = 1 + MUL_LAT + 1 + MUL_LAT + 1 + 1 + 1 + DIV_LAT + 1;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   localparam int REQ_W      = ((9 * COORD_W + 7) / 8) * 8;
   localparam int RSP_W      = ((3 * WGT_W + 2 + 7) / 8) * 8;

   // |n|^2 below this raw value counts as a zero normal
   localparam logic [WIDE_W-1:0] EPS_RAW    = WIDE_W'(184468);
   localparam logic [WGT_W-1:0]  CENTROID_W = WGT_W'(((1 << (WFRAC + 1)) + 3) / 6);

   typedef enum logic [1:0] {
      DEGEN_OK          = 2'd0,
      DEGEN_ZERO_NORMAL = 2'd1
   } degen_type;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;

   // a queued item: vertex A and the edge vectors AB and AC
   typedef struct packed {
      coord_type a_x;
      coord_type a_y;
      coord_type a_z;
      diff_type  ab_x;
      diff_type  ab_y;
      diff_type  ab_z;
      diff_type  ac_x;
      diff_type  ac_y;
      diff_type  ac_z;
   } item_type;

endpackage

FILE: rtl/obw_mul.sv
// ----------------------------------------------------------------------------
// obw_mul - pipelined signed multiplier
// Sign-magnitude, 3x3 limb partial products, four register stages.
// ----------------------------------------------------------------------------
module obw_mul import obw_pkg::*; (
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [MUL_W-1:0]  op_a,
   input  logic signed [MUL_W-1:0]  op_b,
   output logic signed [PROD_W-1:0] prod
);

   logic signed [MUL_W-1:0]  neg_a, neg_b;
   logic [3*LIMB_W-1:0]      mag_a_ff, mag_b_ff;
   logic                     neg1_ff, neg2_ff, neg3_ff;
   logic [2*LIMB_W-1:0]      pp_ff [3][3];
   logic [4*LIMB_W-1:0]      row_ff [3];
   logic [6*LIMB_W-1:0]      total;
   logic [PROD_W-1:0]        mag_p;
   logic signed [PROD_W-1:0] prod_ff;

   assign neg_a = -op_a;
   assign neg_b = -op_b;

   assign total = (6*LIMB_W)'(row_ff[0])
                + ((6*LIMB_W)'(row_ff[1]) << LIMB_W)
                + ((6*LIMB_W)'(row_ff[2]) << (2 * LIMB_W));
   assign mag_p = total[PROD_W-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         mag_a_ff <= (3*LIMB_W)'($unsigned(op_a[MUL_W-1] ? neg_a : op_a));
         mag_b_ff <= (3*LIMB_W)'($unsigned(op_b[MUL_W-1] ? neg_b : op_b));
         neg1_ff  <= op_a[MUL_W-1] ^ op_b[MUL_W-1];
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               pp_ff[i][j] <= mag_a_ff[i*LIMB_W +: LIMB_W] * mag_b_ff[j*LIMB_W +: LIMB_W];
            end
         end
         neg2_ff <= neg1_ff;
         for (int i = 0; i < 3; i++) begin
            row_ff[i] <= (4*LIMB_W)'(pp_ff[i][0])
                       + ((4*LIMB_W)'(pp_ff[i][1]) << LIMB_W)
                       + ((4*LIMB_W)'(pp_ff[i][2]) << (2 * LIMB_W));
         end
         neg3_ff <= neg2_ff;
         prod_ff <= neg3_ff ? -$signed(mag_p) : $signed(mag_p);
      end
   end

   assign prod = prod_ff;

endmodule

FILE: rtl/obw_div.sv
// ----------------------------------------------------------------------------
// obw_div - pipelined restoring divider for one weight
// weight = round(part * 2^WFRAC / total), one quotient bit per stage.
// ----------------------------------------------------------------------------
module obw_div import obw_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [WIDE_W-1:0] part,
   input  logic [WIDE_W-1:0] total,
   output logic [WGT_W-1:0]  weight
);

   logic [NUM_W-1:0]  rem_ff [WGT_W+1];
   logic [WIDE_W:0]   den_ff [WGT_W+1];
   logic [WGT_W-1:0]  quo_ff [WGT_W+1];

   // dividend (2^(F+1)*part + total) over 2*total gives the rounded quotient
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= (NUM_W'(part) << (WFRAC + 1)) + NUM_W'(total);
         den_ff[0] <= {total, 1'b0};
         quo_ff[0] <= '0;
      end
   end

   for (genvar k = 0; k < WGT_W; k++) begin : g_step
      logic [NUM_W-1:0] shifted;
      logic             ge;
      assign shifted = NUM_W'(den_ff[k]) << (WFRAC - k);
      assign ge      = rem_ff[k] >= shifted;
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= ge ? rem_ff[k] - shifted : rem_ff[k];
            den_ff[k+1] <= den_ff[k];
            quo_ff[k+1] <= {quo_ff[k][WGT_W-2:0], ge};
         end
      end
   end

   assign weight = quo_ff[WGT_W];

endmodule

FILE: rtl/obw_front.sv
// ----------------------------------------------------------------------------
// obw_front - input side: unpack, edge vectors, item queue
// Accepts one triangle per cycle while the queue has room.
// ----------------------------------------------------------------------------
module obw_front import obw_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   output logic             item_valid,
   input  logic             item_pop,
   output item_type         item
);

   item_type             entry;
   item_type             fifo_mem [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]     count_ff, count_in;
   logic                 push;
   coord_type            bx, by, bz, cx, cy, cz;

   assign entry.a_x = req_tdata[0*COORD_W +: COORD_W];
   assign entry.a_y = req_tdata[1*COORD_W +: COORD_W];
   assign entry.a_z = req_tdata[2*COORD_W +: COORD_W];
   assign bx        = req_tdata[3*COORD_W +: COORD_W];
   assign by        = req_tdata[4*COORD_W +: COORD_W];
   assign bz        = req_tdata[5*COORD_W +: COORD_W];
   assign cx        = req_tdata[6*COORD_W +: COORD_W];
   assign cy        = req_tdata[7*COORD_W +: COORD_W];
   assign cz        = req_tdata[8*COORD_W +: COORD_W];

   assign entry.ab_x = DIFF_W'(bx) - DIFF_W'(entry.a_x);
   assign entry.ab_y = DIFF_W'(by) - DIFF_W'(entry.a_y);
   assign entry.ab_z = DIFF_W'(bz) - DIFF_W'(entry.a_z);
   assign entry.ac_x = DIFF_W'(cx) - DIFF_W'(entry.a_x);
   assign entry.ac_y = DIFF_W'(cy) - DIFF_W'(entry.a_y);
   assign entry.ac_z = DIFF_W'(cz) - DIFF_W'(entry.a_z);

   assign req_tready = count_ff != (FIFO_AW+1)'(FIFO_DEPTH);
   assign push       = req_tvalid && req_tready;
   assign item_valid = count_ff != '0;
   assign item       = fifo_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push     ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = item_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(item_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[wr_ptr_ff] <= entry;
      end
   end

endmodule

FILE: rtl/obw_back.sv
// ----------------------------------------------------------------------------
// obw_back - arithmetic pipeline and output register
// Normal, Gram terms, Cramer numerators, clamp, three rounding divides.
// ----------------------------------------------------------------------------
module obw_back import obw_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             item_valid,
   output logic             item_pop,
   input  item_type         item,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata
);

   logic                     en;
   logic [PIPE_LAT-1:0]      v_ff;

   coord_type                a_ff  [3];
   diff_type                 ab_ff [3];
   diff_type                 ac_ff [3];

   logic signed [PROD_W-1:0] np [3], nq [3], ep1 [3], ep2 [3];
   logic signed [PROD_W-1:0] dp1 [3], dp2 [3], dp3 [3];
   logic signed [MUL_W-1:0]  n_ff [3];
   logic signed [MUL_W-1:0]  e1_ff, e2_ff, d1_ff, d2_ff, d3_ff;

   logic signed [PROD_W-1:0] nn [3], sp, sq, tp, tq;
   logic signed [WIDE_W-1:0] dd_ff, s_ff, t_ff, u;

   logic [WIDE_W-1:0]        uc_ff, sc_ff, tc_ff, tot_ff, u2_ff, s2_ff, t2_ff;
   logic [DIV_LAT+1:0]       deg_ff;
   logic [WGT_W-1:0]         qa, qb, qc;
   logic [WGT_W-1:0]         wa_ff, wb_ff, wc_ff;
   degen_type                code_ff;
   logic [WGT_W+1:0]         wsum;

   assign rsp_tvalid = v_ff[PIPE_LAT-1];
   assign en         = !rsp_tvalid || rsp_tready;
   assign item_pop   = item_valid && en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[PIPE_LAT-2:0], item_pop};
      end
   end

   // entry registers
   always_ff @(posedge clock) begin
      if (en) begin
         a_ff[0]  <= item.a_x;   a_ff[1]  <= item.a_y;   a_ff[2]  <= item.a_z;
         ab_ff[0] <= item.ab_x;  ab_ff[1] <= item.ab_y;  ab_ff[2] <= item.ab_z;
         ac_ff[0] <= item.ac_x;  ac_ff[1] <= item.ac_y;  ac_ff[2] <= item.ac_z;
      end
   end

   // first product bank: normal terms, A.ab, A.ac, Gram entries
   for (genvar i = 0; i < 3; i++) begin : g_mul1
      localparam int J = (i + 1) % 3;
      localparam int K = (i + 2) % 3;
      obw_mul u_np  (.clock, .en, .op_a(MUL_W'(ab_ff[J])), .op_b(MUL_W'(ac_ff[K])),
                     .prod(np[i]));
      obw_mul u_nq  (.clock, .en, .op_a(MUL_W'(ab_ff[K])), .op_b(MUL_W'(ac_ff[J])),
                     .prod(nq[i]));
      obw_mul u_ep1 (.clock, .en, .op_a(MUL_W'(a_ff[i])), .op_b(MUL_W'(ab_ff[i])),
                     .prod(ep1[i]));
      obw_mul u_ep2 (.clock, .en, .op_a(MUL_W'(a_ff[i])), .op_b(MUL_W'(ac_ff[i])),
                     .prod(ep2[i]));
      obw_mul u_dp1 (.clock, .en, .op_a(MUL_W'(ab_ff[i])), .op_b(MUL_W'(ab_ff[i])),
                     .prod(dp1[i]));
      obw_mul u_dp2 (.clock, .en, .op_a(MUL_W'(ab_ff[i])), .op_b(MUL_W'(ac_ff[i])),
                     .prod(dp2[i]));
      obw_mul u_dp3 (.clock, .en, .op_a(MUL_W'(ac_ff[i])), .op_b(MUL_W'(ac_ff[i])),
                     .prod(dp3[i]));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            n_ff[i] <= MUL_W'(np[i] - nq[i]);
         end
         e1_ff <= MUL_W'(-(ep1[0] + ep1[1] + ep1[2]));
         e2_ff <= MUL_W'(-(ep2[0] + ep2[1] + ep2[2]));
         d1_ff <= MUL_W'(dp1[0] + dp1[1] + dp1[2]);
         d2_ff <= MUL_W'(dp2[0] + dp2[1] + dp2[2]);
         d3_ff <= MUL_W'(dp3[0] + dp3[1] + dp3[2]);
      end
   end

   // second product bank: |n|^2 and Cramer numerators
   for (genvar i = 0; i < 3; i++) begin : g_nn
      obw_mul u_nn (.clock, .en, .op_a(n_ff[i]), .op_b(n_ff[i]), .prod(nn[i]));
   end
   obw_mul u_sp (.clock, .en, .op_a(e1_ff), .op_b(d3_ff), .prod(sp));
   obw_mul u_sq (.clock, .en, .op_a(e2_ff), .op_b(d2_ff), .prod(sq));
   obw_mul u_tp (.clock, .en, .op_a(e2_ff), .op_b(d1_ff), .prod(tp));
   obw_mul u_tq (.clock, .en, .op_a(e1_ff), .op_b(d2_ff), .prod(tq));

   always_ff @(posedge clock) begin
      if (en) begin
         dd_ff <= WIDE_W'(nn[0]) + WIDE_W'(nn[1]) + WIDE_W'(nn[2]);
         s_ff  <= WIDE_W'(sp) - WIDE_W'(sq);
         t_ff  <= WIDE_W'(tp) - WIDE_W'(tq);
      end
   end

   // clamp numerators at zero, flag a vanishing normal
   assign u = dd_ff - s_ff - t_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         uc_ff     <= u[WIDE_W-1]     ? '0 : $unsigned(u);
         sc_ff     <= s_ff[WIDE_W-1]  ? '0 : $unsigned(s_ff);
         tc_ff     <= t_ff[WIDE_W-1]  ? '0 : $unsigned(t_ff);
         deg_ff[0] <= $unsigned(dd_ff) < EPS_RAW;
         tot_ff    <= uc_ff + sc_ff + tc_ff;
         u2_ff     <= uc_ff;
         s2_ff     <= sc_ff;
         t2_ff     <= tc_ff;
         deg_ff[DIV_LAT+1:1] <= deg_ff[DIV_LAT:0];
      end
   end

   obw_div u_div_a (.clock, .en, .part(u2_ff), .total(tot_ff), .weight(qa));
   obw_div u_div_b (.clock, .en, .part(s2_ff), .total(tot_ff), .weight(qb));
   obw_div u_div_c (.clock, .en, .part(t2_ff), .total(tot_ff), .weight(qc));

   // output register: centroid on a degenerate triangle
   always_ff @(posedge clock) begin
      if (en) begin
         if (deg_ff[DIV_LAT+1]) begin
            wa_ff   <= CENTROID_W;
            wb_ff   <= CENTROID_W;
            wc_ff   <= CENTROID_W;
            code_ff <= DEGEN_ZERO_NORMAL;
         end else begin
            wa_ff   <= qa;
            wb_ff   <= qb;
            wc_ff   <= qc;
            code_ff <= DEGEN_OK;
         end
      end
   end

   assign rsp_tdata = RSP_W'({code_ff, wc_ff, wb_ff, wa_ff});
   assign wsum      = (WGT_W+2)'(wa_ff) + (WGT_W+2)'(wb_ff) + (WGT_W+2)'(wc_ff);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(v_ff))
      else $error("pipeline moved while stalled");

   a_sum_one: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && code_ff == DEGEN_OK) |->
         (wsum >= (WGT_W+2)'((1 << WFRAC) - 1) && wsum <= (WGT_W+2)'((1 << WFRAC) + 1)))
      else $error("weights do not sum to one");

   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && code_ff == DEGEN_OK) |->
         (wa_ff <= WGT_W'(1 << WFRAC) && wb_ff <= WGT_W'(1 << WFRAC)
          && wc_ff <= WGT_W'(1 << WFRAC)))
      else $error("weight above one");

   a_centroid: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && code_ff == DEGEN_ZERO_NORMAL) |->
         (wa_ff == CENTROID_W && wb_ff == CENTROID_W && wc_ff == CENTROID_W))
      else $error("degenerate result without centroid weights");

endmodule

FILE: rtl/origin_barycentric_weights.sv
// ----------------------------------------------------------------------------
// origin_barycentric_weights - barycentric weights of the origin's projection
// Projects the origin onto a triangle's plane and returns clamped, normalized
// Q1.16 weights for the three vertices.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one transfer carries a triangle, nine signed Q16.16
//    coordinates. rsp channel: one transfer per triangle, in order.
//  - Throughput: one triangle per cycle, fully pipelined, while no result
//    waits on rsp_tready; no state is kept between triangles.
//  - Path: a req transfer passes through the queue, the entry registers,
//    the multipliers twice, the clamp, then a 17-step pipelined divider
//    per weight, and the output register drives rsp_tdata.
//  - A 4-entry queue sits between the input side and the arithmetic
//    pipeline. While a result waits with rsp_tready low the pipeline holds;
//    the queue keeps taking triangles until it fills, then req_tready drops.
//  - Reset (synchronous) empties the queue and the pipeline; no results
//    are pending afterward.
//  - degenerate_code 1 marks a near-zero normal; the weights are then the
//    centroid, 21845 each.
// ----------------------------------------------------------------------------
module origin_barycentric_weights import obw_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // point_a_x, point_a_y, point_a_z, point_b_x, point_b_y, point_b_z,
   // point_c_x, point_c_y, point_c_z
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // weight_a, weight_b, weight_c, degenerate_code, zero fill
   output logic [RSP_W-1:0] rsp_tdata
);

   logic     item_valid;
   logic     item_pop;
   item_type item;

   obw_front u_front (
      .clock,
      .reset,
      .req_tvalid,
      .req_tready,
      .req_tdata,
      .item_valid,
      .item_pop,
      .item
   );

   obw_back u_back (
      .clock,
      .reset,
      .item_valid,
      .item_pop,
      .item,
      .rsp_tvalid,
      .rsp_tready,
      .rsp_tdata
   );

endmodule

FILE: verif/obw_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// obw_checker - result predictor and scoreboard for origin_barycentric_weights
// Watches both streams, computes the expected weights of every accepted
// triangle with exact wide integer arithmetic and compares each result.
// ----------------------------------------------------------------------------
module obw_checker import obw_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,
   output int               fail_count,
   output int               pending_count
);

   typedef logic signed [255:0] big_type;

   typedef struct packed {
      logic [WGT_W-1:0] w_a;
      logic [WGT_W-1:0] w_b;
      logic [WGT_W-1:0] w_c;
      logic [1:0]       code;
   } weights_type;

   weights_type expected_weights[$];

   function automatic logic [WGT_W-1:0] round_weight(big_type x, big_type sum);
      big_type q;
      q = ((x <<< (WFRAC + 1)) + sum) / (sum <<< 1);
      return q[WGT_W-1:0];
   endfunction

   function automatic weights_type project_weights(logic [REQ_W-1:0] d);
      big_type a[3], ab[3], ac[3], n[3];
      big_type dd, e1, e2, d1, d2, d3, s, t, u, sum;
      weights_type r;
      for (int i = 0; i < 3; i++) begin
         a[i]  = big_type'($signed(d[i*COORD_W +: COORD_W]));
         ab[i] = big_type'($signed(d[(3+i)*COORD_W +: COORD_W])) - a[i];
         ac[i] = big_type'($signed(d[(6+i)*COORD_W +: COORD_W])) - a[i];
      end
      for (int i = 0; i < 3; i++)
         n[i] = ab[(i+1)%3] * ac[(i+2)%3] - ab[(i+2)%3] * ac[(i+1)%3];
      dd = n[0]*n[0] + n[1]*n[1] + n[2]*n[2];
      if (dd < big_type'(EPS_RAW)) begin
         r.w_a  = CENTROID_W;
         r.w_b  = CENTROID_W;
         r.w_c  = CENTROID_W;
         r.code = DEGEN_ZERO_NORMAL;
         return r;
      end
      e1 = -(a[0]*ab[0] + a[1]*ab[1] + a[2]*ab[2]);
      e2 = -(a[0]*ac[0] + a[1]*ac[1] + a[2]*ac[2]);
      d1 = ab[0]*ab[0] + ab[1]*ab[1] + ab[2]*ab[2];
      d2 = ab[0]*ac[0] + ab[1]*ac[1] + ab[2]*ac[2];
      d3 = ac[0]*ac[0] + ac[1]*ac[1] + ac[2]*ac[2];
      s = e1*d3 - e2*d2;
      t = e2*d1 - e1*d2;
      u = dd - s - t;
      if (u < 0) u = 0;
      if (s < 0) s = 0;
      if (t < 0) t = 0;
      sum = u + s + t;
      r.w_a  = round_weight(u, sum);
      r.w_b  = round_weight(s, sum);
      r.w_c  = round_weight(t, sum);
      r.code = DEGEN_OK;
      return r;
   endfunction

   assign pending_count = expected_weights.size();

   always @(posedge clock) begin
      weights_type got, want;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_weights.push_back(project_weights(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got.w_a  = rsp_tdata[0 +: WGT_W];
            got.w_b  = rsp_tdata[WGT_W +: WGT_W];
            got.w_c  = rsp_tdata[2*WGT_W +: WGT_W];
            got.code = rsp_tdata[3*WGT_W +: 2];
            if (expected_weights.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_weights.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display({"mismatch: exp a=%0d b=%0d c=%0d code=%0d,",
                               " got a=%0d b=%0d c=%0d code=%0d"},
                        want.w_a, want.w_b, want.w_c, want.code,
                        got.w_a, got.w_b, got.w_c, got.code);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

FILE: verif/tb_origin_barycentric_weights.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_origin_barycentric_weights - stream test of the barycentric weight unit
// Drives directed and random triangles with random gaps and back pressure;
// a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_origin_barycentric_weights;
   import obw_pkg::*;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   int               fail_count;
   int               pending_count;
   int               cycle_count = 0;
   bit               calm = 1'b0;     // no idling on either side
   bit               hold_rsp = 1'b0; // long receiver hold-off

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   origin_barycentric_weights DUT (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

   obw_checker checker_i (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .fail_count, .pending_count
   );

   // cycle limit: all 1224 transfers with random gaps and stalls fit easily
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // receiver: random stalls, a long hold-off, calm stretch
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= !hold_rsp && (calm || $urandom_range(99) >= 21);
   end

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(5))
         0: return $urandom();                             // full range
         1: return 32'h8000_0000 | $urandom_range(3);
         2: return 32'h7fff_ffff - $urandom_range(3);
         3: return 32'($signed($urandom_range(2000)) - 1000);
         default: return 32'($signed($urandom_range(20 << 16)) - (10 << 16));
      endcase
   endfunction

   // one triangle transfer, with a random gap before it
   task automatic send_tri(logic [31:0] c[9]);
      logic [REQ_W-1:0] d;
      d = '0;
      for (int i = 0; i < 9; i++) d[i*32 +: 32] = c[i];
      while (!calm && $urandom_range(99) < 21) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_random(int count);
      logic [31:0] c[9];
      for (int k = 0; k < count; k++) begin
         for (int i = 0; i < 9; i++) c[i] = rand_coord();
         case ($urandom_range(9))
            0: c[3:5] = c[0:2];                      // A == B
            1: for (int i = 0; i < 3; i++) c[6+i] = c[i] + c[i] - c[3+i]; // collinear
            2: for (int i = 0; i < 9; i++) c[i] = 32'($signed($urandom_range(6)) - 3);
            default: ;
         endcase
         send_tri(c);
      end
   endtask

   task automatic idle_until_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      logic [31:0] c[9];
      int waited;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, zero and degenerate shapes
      c = '{default: 32'h0};                          send_tri(c);
      c = '{default: 32'h8000_0000};                  send_tri(c);
      c = '{default: 32'h7fff_ffff};                  send_tri(c);
      c = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff}; send_tri(c);
      c = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
            32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
            32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000}; send_tri(c);
      // unit triangle around the origin plane, interior and outside projections
      c = '{32'h1_0000, 0, 0, 0, 32'h1_0000, 0, 0, 0, 32'h1_0000}; send_tri(c);
      c = '{32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h2_0000, 32'h1_0000, 32'h1_0000,
            32'h1_0000, 32'h2_0000, 32'h1_0000};                   send_tri(c);
      c = '{32'hffff_0000, 0, 32'h1_0000, 32'h1_0000, 0, 32'h1_0000,
            0, 32'h1_0000, 32'h1_0000};                            send_tri(c);
      // tiny triangles near the zero-normal threshold
      c = '{0, 0, 0, 1, 0, 0, 0, 1, 0};                            send_tri(c);
      c = '{0, 0, 0, 32'd20, 0, 0, 0, 32'd20, 0};                  send_tri(c);
      c = '{0, 0, 0, 32'd21, 0, 0, 0, 32'd21, 0};                  send_tri(c);
      c = '{5, 5, 5, 32'd25, 5, 5, 5, 32'd26, 5};                  send_tri(c);
      // collinear vertices, then a mixed bit-pattern triangle
      c = '{32'h1_0000, 32'h1_0000, 0, 32'h2_0000, 32'h2_0000, 0,
            32'h3_0000, 32'h3_0000, 0};                            send_tri(c);
      c = '{32'haaaa_aaaa, 32'h5555_5555, 32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa,
            32'h0000_0001, 32'hf0f0_f0f0, 32'h0f0f_0f0f, 32'h1234_5678}; send_tri(c);
      idle_until_drained();  // sender pause until all results are back

      send_random(400);

      // receiver holds off while the sender keeps offering; more items than
      // the pipeline and queue can hold, so req_tready drops
      hold_rsp <= 1'b1;
      fork
         send_random(60);
         begin
            waited = 0;
            while (waited < 300) begin
               @(posedge clock);
               waited++;
            end
            hold_rsp <= 1'b0;
         end
      join

      calm <= 1'b1;
      send_random(250);
      calm <= 1'b0;
      send_random(500);
      idle_until_drained();
      repeat (60) @(posedge clock);

      if (fail_count == 0 && pending_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
